FILE: sv/bsp_pkg.sv
// shared types, constants and helpers for the billboard sprite projection
`default_nettype none

package bsp_pkg;

  localparam int SCREEN_COLS = 640;
  localparam int SCREEN_ROWS = 480;

  // one quotient bit per divider stage
  localparam int DIV_STEPS = 32;

  // input skew (2) + three dividers (33 each) + two clamp stages + output stage
  localparam int PIPE_LAT = 2 + 3 * (DIV_STEPS + 1) + 2 + 1;

  typedef enum logic [1:0] {
    ST_FRONT    = 2'd0,
    ST_BEHIND   = 2'd1,
    ST_SINGULAR = 2'd2
  } status_t;

  typedef struct packed {
    logic [31:0] mag;
    logic        ovf;
    logic        neg;
  } div_res_t;

  // signed quotient from magnitude, clamped to the int32 range
  function automatic logic signed [31:0] sat32(input div_res_t r);
    logic signed [31:0] res;
    if (r.neg) begin
      if (r.ovf || (r.mag > 32'h8000_0000)) res = 32'sh8000_0000;
      else res = $signed(-r.mag);
    end else begin
      if (r.ovf || r.mag[31]) res = 32'sh7fff_ffff;
      else res = $signed(r.mag);
    end
    return res;
  endfunction

  function automatic logic [15:0] sat16(input logic signed [31:0] x);
    logic [15:0] res;
    if (x > 32'sd32767) res = 16'h7fff;
    else if (x < -32'sd32768) res = 16'h8000;
    else res = x[15:0];
    return res;
  endfunction

  function automatic logic [35:0] clamp_idx(input logic signed [35:0] x,
                                            input logic signed [35:0] hi);
    logic [35:0] res;
    if (x < 36'sd0) res = '0;
    else if (x > hi) res = hi;
    else res = x;
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: sv/bsp_div.sv
// pipelined restoring divider, one quotient bit per stage, saturation flag
`default_nettype none

module bsp_div (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [63:0]       num_i,
  input  wire logic [31:0]       den_i,
  input  wire logic              neg_i,
  output bsp_pkg::div_res_t      res_o
);

  localparam int N = bsp_pkg::DIV_STEPS;

  logic [31:0] rem_r [N+1];
  logic [31:0] lo_r  [N+1];
  logic [31:0] quo_r [N+1];
  logic [31:0] den_r [N+1];
  logic        ovf_r [N+1];
  logic        neg_r [N+1];

  logic [32:0] trial_w [N];
  logic [32:0] diff_w  [N];
  logic        fit_w   [N];

  always_comb begin
    for (int k = 0; k < N; k++) begin
      trial_w[k] = {rem_r[k], lo_r[k][31]};
      diff_w[k]  = trial_w[k] - {1'b0, den_r[k]};
      fit_w[k]   = trial_w[k] >= {1'b0, den_r[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // quotient needs more than 32 bits when the high word reaches the divisor
      rem_r[0] <= num_i[63:32];
      lo_r[0]  <= num_i[31:0];
      quo_r[0] <= '0;
      den_r[0] <= den_i;
      ovf_r[0] <= num_i[63:32] >= den_i;
      neg_r[0] <= neg_i;
      for (int k = 0; k < N; k++) begin
        rem_r[k+1] <= fit_w[k] ? diff_w[k][31:0] : trial_w[k][31:0];
        lo_r[k+1]  <= {lo_r[k][30:0], 1'b0};
        quo_r[k+1] <= {quo_r[k][30:0], fit_w[k]};
        den_r[k+1] <= den_r[k];
        ovf_r[k+1] <= ovf_r[k];
        neg_r[k+1] <= neg_r[k];
      end
    end
  end

  assign res_o.mag = quo_r[N];
  assign res_o.ovf = ovf_r[N];
  assign res_o.neg = neg_r[N];

endmodule

`default_nettype wire

FILE: sv/billboard_sprite_projection.sv
// top level: billboard sprite projection pipeline
`default_nettype none

// Projects one billboard sprite per beat into screen space. The sprite offset
// from the camera is moved into camera space with the inverse of [plane dir],
// then the center column, projected width and height, vertical shift from lift,
// depth and the clamped screen rectangle follow. A fully pipelined datapath
// takes one beat every cycle unless the output stalls; its length is mostly
// three chained 33-stage restoring dividers (camera transform; lift, center and
// base size over depth; size over the width and height divisors). The whole
// pipeline holds while a result waits and out_tready is low, so nothing is
// lost or repeated. Status travels on out_tuser: 0 in front, 1 depth not
// positive (only depth valid), 2 singular camera (all fields zero). A zero
// divisor acts as one.

module billboard_sprite_projection (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // sprite_x, sprite_y, cam_x, cam_y, dir_x, dir_y, plane_x, plane_y, lift,
  // width_divisor, height_divisor
  input  wire logic [239:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // center_col, first_col, last_col, first_row, last_row, span_width,
  // span_height, row_shift, depth, two zero pad bits
  output logic [135:0]      out_tdata,
  // status
  output logic [1:0]        out_tuser
);

  localparam int LAT = bsp_pkg::PIPE_LAT;
  localparam int DL  = bsp_pkg::DIV_STEPS + 1;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] depth;
    logic [15:0] row_shift;
    logic [15:0] span_height;
    logic [15:0] span_width;
    logic [8:0]  last_row;
    logic [8:0]  first_row;
    logic [9:0]  last_col;
    logic [9:0]  first_col;
    logic [15:0] center_col;
  } out_beat_t;

  typedef struct packed {
    logic        sing;
    logic [31:0] lift;
    logic [7:0]  wdiv;
    logic [7:0]  hdiv;
  } side1_t;

  typedef struct packed {
    logic        sing;
    logic [31:0] ty;
    logic [7:0]  wdiv;
    logic [7:0]  hdiv;
  } side2_t;

  typedef struct packed {
    logic        sing;
    logic [31:0] ty;
    logic [31:0] v;
    logic [31:0] cx;
  } side3_t;

  // whole pipeline advances together; holds only while a result is refused
  logic en;
  logic [LAT-1:0] vld_r;

  assign en        = !vld_r[LAT-1] || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  // input fields
  logic signed [31:0] sprite_x, sprite_y, cam_x, cam_y, lift;
  logic signed [15:0] dir_x, dir_y, plane_x, plane_y;
  logic [7:0]         width_divisor, height_divisor;

  assign sprite_x       = $signed(in_tdata[31:0]);
  assign sprite_y       = $signed(in_tdata[63:32]);
  assign cam_x          = $signed(in_tdata[95:64]);
  assign cam_y          = $signed(in_tdata[127:96]);
  assign dir_x          = $signed(in_tdata[143:128]);
  assign dir_y          = $signed(in_tdata[159:144]);
  assign plane_x        = $signed(in_tdata[175:160]);
  assign plane_y        = $signed(in_tdata[191:176]);
  assign lift           = $signed(in_tdata[223:192]);
  assign width_divisor  = in_tdata[231:224];
  assign height_divisor = in_tdata[239:232];

  // stage a: world offset and camera determinant
  logic signed [32:0] dx_r, dy_r, det_r;
  logic signed [15:0] dir_x_r, dir_y_r, plane_x_r, plane_y_r;
  logic signed [31:0] lift_a_r;
  logic [7:0]         wdiv_a_r, hdiv_a_r;
  logic signed [31:0] pd_w, dp_w;

  assign pd_w = plane_x * dir_y;
  assign dp_w = dir_x * plane_y;

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r      <= sprite_x - cam_x;
      dy_r      <= sprite_y - cam_y;
      det_r     <= pd_w - dp_w;
      dir_x_r   <= dir_x;
      dir_y_r   <= dir_y;
      plane_x_r <= plane_x;
      plane_y_r <= plane_y;
      lift_a_r  <= lift;
      // a zero divisor acts as one
      wdiv_a_r  <= (width_divisor == '0) ? 8'd1 : width_divisor;
      hdiv_a_r  <= (height_divisor == '0) ? 8'd1 : height_divisor;
    end
  end

  // stage b: camera-space numerators
  logic signed [48:0] p1_w, p2_w, p3_w, p4_w;
  logic signed [49:0] nx_r, ny_r;
  logic signed [32:0] det_b_r;
  side1_t             side_b_r;

  assign p1_w = dir_y_r * dx_r;
  assign p2_w = dir_x_r * dy_r;
  assign p3_w = plane_x_r * dy_r;
  assign p4_w = plane_y_r * dx_r;

  always_ff @(posedge clk) begin
    if (en) begin
      nx_r          <= p1_w - p2_w;
      ny_r          <= p3_w - p4_w;
      det_b_r       <= det_r;
      side_b_r.sing <= det_r == '0;
      side_b_r.lift <= lift_a_r;
      side_b_r.wdiv <= wdiv_a_r;
      side_b_r.hdiv <= hdiv_a_r;
    end
  end

  // divider 1: tx and ty, numerators scaled by 2^14
  logic [49:0] nx_abs_w, ny_abs_w;
  logic [32:0] det_abs_w;
  bsp_pkg::div_res_t tx_res_w, ty_res_w;

  assign nx_abs_w  = nx_r[49] ? 50'(-nx_r) : 50'(nx_r);
  assign ny_abs_w  = ny_r[49] ? 50'(-ny_r) : 50'(ny_r);
  assign det_abs_w = det_b_r[32] ? 33'(-det_b_r) : 33'(det_b_r);

  bsp_div u_div_tx (
    .clk   (clk),
    .en    (en),
    .num_i ({nx_abs_w, 14'b0}),
    .den_i (det_abs_w[31:0]),
    .neg_i (nx_r[49] ^ det_b_r[32]),
    .res_o (tx_res_w)
  );

  bsp_div u_div_ty (
    .clk   (clk),
    .en    (en),
    .num_i ({ny_abs_w, 14'b0}),
    .den_i (det_abs_w[31:0]),
    .neg_i (ny_r[49] ^ det_b_r[32]),
    .res_o (ty_res_w)
  );

  side1_t side1_r [DL];

  always_ff @(posedge clk) begin
    if (en) begin
      side1_r[0] <= side_b_r;
      for (int k = 1; k < DL; k++) side1_r[k] <= side1_r[k-1];
    end
  end

  // stage d: saturated tx, ty
  logic signed [31:0] tx_r, ty_r, lift_d_r;
  side2_t             side_d_r;

  always_ff @(posedge clk) begin
    if (en) begin
      tx_r          <= bsp_pkg::sat32(tx_res_w);
      ty_r          <= bsp_pkg::sat32(ty_res_w);
      lift_d_r      <= side1_r[DL-1].lift;
      side_d_r.sing <= side1_r[DL-1].sing;
      side_d_r.ty   <= bsp_pkg::sat32(ty_res_w);
      side_d_r.wdiv <= side1_r[DL-1].wdiv;
      side_d_r.hdiv <= side1_r[DL-1].hdiv;
    end
  end

  // divider 2: lift, center and base size over depth
  logic signed [32:0] sum_w;
  logic signed [42:0] cxm_w;
  logic [42:0]        cxm_abs_w;
  logic [31:0]        lift_abs_w;
  bsp_pkg::div_res_t  v_res_w, cx_res_w, base_res_w;

  assign sum_w      = tx_r + ty_r;
  assign cxm_w      = sum_w * $signed(43'(bsp_pkg::SCREEN_COLS / 2));
  assign cxm_abs_w  = cxm_w[42] ? 43'(-cxm_w) : 43'(cxm_w);
  assign lift_abs_w = lift_d_r[31] ? 32'(-lift_d_r) : 32'(lift_d_r);

  bsp_div u_div_v (
    .clk   (clk),
    .en    (en),
    .num_i ({32'b0, lift_abs_w}),
    .den_i (ty_r),
    .neg_i (lift_d_r[31]),
    .res_o (v_res_w)
  );

  bsp_div u_div_cx (
    .clk   (clk),
    .en    (en),
    .num_i ({21'b0, cxm_abs_w}),
    .den_i (ty_r),
    .neg_i (cxm_w[42]),
    .res_o (cx_res_w)
  );

  bsp_div u_div_base (
    .clk   (clk),
    .en    (en),
    .num_i (64'(bsp_pkg::SCREEN_ROWS * 65536)),
    .den_i (ty_r),
    .neg_i (1'b0),
    .res_o (base_res_w)
  );

  side2_t side2_r [DL];

  always_ff @(posedge clk) begin
    if (en) begin
      side2_r[0] <= side_d_r;
      for (int k = 1; k < DL; k++) side2_r[k] <= side2_r[k-1];
    end
  end

  // stage e: saturated shift, center and base size
  logic [31:0] base_r;
  logic [7:0]  wdiv_e_r, hdiv_e_r;
  side3_t      side_e_r;

  always_ff @(posedge clk) begin
    if (en) begin
      base_r        <= bsp_pkg::sat32(base_res_w);
      wdiv_e_r      <= side2_r[DL-1].wdiv;
      hdiv_e_r      <= side2_r[DL-1].hdiv;
      side_e_r.sing <= side2_r[DL-1].sing;
      side_e_r.ty   <= side2_r[DL-1].ty;
      side_e_r.v    <= bsp_pkg::sat32(v_res_w);
      side_e_r.cx   <= bsp_pkg::sat32(cx_res_w);
    end
  end

  // divider 3: height and width over their divisors
  bsp_pkg::div_res_t h_res_w, w_res_w;

  bsp_div u_div_h (
    .clk   (clk),
    .en    (en),
    .num_i ({32'b0, base_r}),
    .den_i ({24'b0, hdiv_e_r}),
    .neg_i (1'b0),
    .res_o (h_res_w)
  );

  bsp_div u_div_w (
    .clk   (clk),
    .en    (en),
    .num_i ({32'b0, base_r}),
    .den_i ({24'b0, wdiv_e_r}),
    .neg_i (1'b0),
    .res_o (w_res_w)
  );

  side3_t side3_r [DL];

  always_ff @(posedge clk) begin
    if (en) begin
      side3_r[0] <= side_e_r;
      for (int k = 1; k < DL; k++) side3_r[k] <= side3_r[k-1];
    end
  end

  // final: rectangle bounds, clamps and status
  localparam logic signed [35:0] HALF_ROWS = 36'(bsp_pkg::SCREEN_ROWS / 2);
  localparam logic signed [35:0] ROW_MAX   = 36'(bsp_pkg::SCREEN_ROWS - 1);
  localparam logic signed [35:0] COL_MAX   = 36'(bsp_pkg::SCREEN_COLS - 1);

  side3_t             fin_w;
  logic [31:0]        h_w, w_w;
  logic signed [35:0] v_ext_w, cx_ext_w, hh_w, wh_w;
  logic signed [35:0] r0_w, r1_w, c0_w, c1_w;
  logic [35:0]        r0c_w, r1c_w, c0c_w, c1c_w;
  out_beat_t          beat_nxt;
  out_beat_t          beat_r;

  assign fin_w    = side3_r[DL-1];
  assign h_w      = h_res_w.mag;
  assign w_w      = w_res_w.mag;
  assign v_ext_w  = 36'($signed(fin_w.v));
  assign cx_ext_w = 36'($signed(fin_w.cx));
  assign hh_w     = $signed({5'b0, h_w[31:1]});
  assign wh_w     = $signed({5'b0, w_w[31:1]});
  assign r0_w     = HALF_ROWS + v_ext_w - hh_w;
  assign r1_w     = HALF_ROWS + v_ext_w + hh_w;
  assign c0_w     = cx_ext_w - wh_w;
  assign c1_w     = cx_ext_w + wh_w;
  assign r0c_w    = bsp_pkg::clamp_idx(r0_w, ROW_MAX);
  assign r1c_w    = bsp_pkg::clamp_idx(r1_w, ROW_MAX);
  assign c0c_w    = bsp_pkg::clamp_idx(c0_w, COL_MAX);
  assign c1c_w    = bsp_pkg::clamp_idx(c1_w, COL_MAX);

  always_comb begin
    beat_nxt = '0;
    if (fin_w.sing) begin
      beat_nxt.status = bsp_pkg::ST_SINGULAR;
    end else if (fin_w.ty[31] || (fin_w.ty == '0)) begin
      beat_nxt.status = bsp_pkg::ST_BEHIND;
      beat_nxt.depth  = fin_w.ty;
    end else begin
      beat_nxt.status      = bsp_pkg::ST_FRONT;
      beat_nxt.depth       = fin_w.ty;
      beat_nxt.center_col  = bsp_pkg::sat16(fin_w.cx);
      beat_nxt.row_shift   = bsp_pkg::sat16(fin_w.v);
      beat_nxt.span_width  = (w_w[31:16] != '0) ? 16'hffff : w_w[15:0];
      beat_nxt.span_height = (h_w[31:16] != '0) ? 16'hffff : h_w[15:0];
      beat_nxt.first_col   = c0c_w[9:0];
      beat_nxt.last_col    = c1c_w[9:0];
      beat_nxt.first_row   = r0c_w[8:0];
      beat_nxt.last_row    = r1c_w[8:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      beat_r <= beat_nxt;
    end
  end

  assign out_tvalid = vld_r[LAT-1];
  assign out_tdata  = {2'b00, beat_r[133:0]};
  assign out_tuser  = beat_r.status;

  // a singular camera never reports a depth or a size
  a_singular_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (beat_r.status == bsp_pkg::ST_SINGULAR)) |->
      ((beat_r.depth == '0) && (beat_r.span_width == '0) && (beat_r.last_col == '0)))
    else $error("singular result carries data");

  // a sprite at or behind the camera has a non-positive depth and no size
  a_behind_depth : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (beat_r.status == bsp_pkg::ST_BEHIND)) |->
      ((beat_r.depth[31] || (beat_r.depth == '0)) && (beat_r.span_height == '0)))
    else $error("behind result inconsistent");

  // a sprite in front always has a positive depth
  a_front_depth : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (beat_r.status == bsp_pkg::ST_FRONT)) |->
      (!beat_r.depth[31] && (beat_r.depth != '0)))
    else $error("front result without positive depth");

  // rectangle bounds stay on screen
  a_bounds : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      ((36'(beat_r.last_col) <= COL_MAX) && (36'(beat_r.first_col) <= COL_MAX)
       && (36'(beat_r.last_row) <= ROW_MAX) && (36'(beat_r.first_row) <= ROW_MAX)))
    else $error("rectangle bound off screen");

  // a stalled output holds the pipeline input closed
  a_stall_holds : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("input taken during output stall");

endmodule

`default_nettype wire
